// ----- design/cla_pkg.sv -----
`default_nettype none
package cla_pkg;

	localparam int LINE_DEPTH = 32;
	localparam int IDX_W = $clog2(LINE_DEPTH);
	localparam int CNT_W = $clog2(LINE_DEPTH + 1);

	localparam logic [7:0] CH_CR   = 8'h0D;
	localparam logic [7:0] CH_LF   = 8'h0A;
	localparam logic [7:0] CH_STAR = 8'h2A;
	localparam logic [7:0] CH_SEMI = 8'h3B;

	localparam int SUM_SHIFT = 3;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_CSUM = 2'd1;
	localparam logic [1:0] ST_OVF  = 2'd2;

	// controller to datapath
	typedef struct packed {
		logic take_byte;
		logic take_term;
		logic rd;
		logic put_data;
		logic put_term;
	} cla_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_term;
		logic stream;
		logic out_free;
		logic rd_last;
	} cla_sts_t;

	// two shift-adds then fold the high byte into the low byte
	function automatic logic [15:0] sum_step(input logic [15:0] s, input logic [7:0] b);
		logic [15:0] t;
		t = (s << SUM_SHIFT) + {8'd0, b};
		t = (t << SUM_SHIFT) + {8'd0, b};
		return t ^ (t >> 8);
	endfunction

endpackage
`default_nettype wire

// ----- design/cla_ctrl.sv -----
`default_nettype none
module cla_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire cla_pkg::cla_sts_t sts,
	output cla_pkg::cla_cmd_t      cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_RD,
		S_PUT,
		S_FIN
	} state_t;

	state_t state_q;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				cmd.take_byte = in_valid && !sts.is_term;
				cmd.take_term = in_valid && sts.is_term;
			end
			S_RD:  cmd.rd = 1'b1;
			S_PUT: cmd.put_data = sts.out_free;
			S_FIN: cmd.put_term = sts.out_free;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && sts.is_term)
						state_q <= sts.stream ? S_RD : S_FIN;
				end
				S_RD: state_q <= S_PUT;
				S_PUT: begin
					if (sts.out_free)
						state_q <= sts.rd_last ? S_FIN : S_RD;
				end
				S_FIN: begin
					if (sts.out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- design/cla_dpath.sv -----
`default_nettype none
module cla_dpath (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_valid,
	input  wire logic              check_enable,
	input  wire logic [7:0]        rx_byte,
	input  wire cla_pkg::cla_cmd_t cmd,
	output cla_pkg::cla_sts_t      sts,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [7:0]             out_byte,
	output logic [1:0]             status,
	output logic                   last
);

	logic [7:0] mem [cla_pkg::LINE_DEPTH];

	logic                      chk_en_q;
	logic [cla_pkg::CNT_W-1:0] fill_q;
	logic                      comment_q;
	logic                      ovf_q;
	logic [15:0]               sum_q;
	logic                      star_q;
	logic [7:0]                chk_q;
	logic                      capt_q;

	logic [cla_pkg::IDX_W-1:0] rd_q;
	logic [cla_pkg::IDX_W-1:0] last_idx_q;
	logic [7:0]                rd_data_q;
	logic [7:0]                term_q;
	logic [1:0]                code_q;
	logic                      out_valid_q;
	logic [7:0]                out_byte_q;
	logic [1:0]                status_q;
	logic                      last_q;

	logic comment_nx;
	logic room;
	logic store_en;
	logic chk_fail;
	logic [cla_pkg::CNT_W-1:0] fill_m1;

	assign comment_nx = comment_q || (rx_byte == cla_pkg::CH_SEMI);
	assign room       = fill_q < cla_pkg::CNT_W'(cla_pkg::LINE_DEPTH);
	assign store_en   = cmd.take_byte && room && !comment_nx;
	assign chk_fail   = chk_en_q && !(star_q && capt_q && (sum_q[7:0] == chk_q));
	assign fill_m1    = fill_q - cla_pkg::CNT_W'(1);

	assign sts.is_term  = (rx_byte == cla_pkg::CH_CR) || (rx_byte == cla_pkg::CH_LF);
	assign sts.stream   = !ovf_q && !chk_fail && (fill_q != '0);
	assign sts.out_free = !out_valid_q || !out_stall;
	assign sts.rd_last  = (rd_q == last_idx_q);

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign status    = status_q;
	assign last      = last_q;

	always_ff @(posedge clk) begin
		if (store_en)
			mem[fill_q[cla_pkg::IDX_W-1:0]] <= rx_byte;
		if (cmd.rd)
			rd_data_q <= mem[rd_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chk_en_q   <= 1'b0;
			fill_q     <= '0;
			comment_q  <= 1'b0;
			ovf_q      <= 1'b0;
			sum_q      <= '0;
			star_q     <= 1'b0;
			chk_q      <= '0;
			capt_q     <= 1'b0;
			rd_q       <= '0;
			last_idx_q <= '0;
			code_q     <= cla_pkg::ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid)
				chk_en_q <= check_enable;

			if (cmd.take_byte) begin
				comment_q <= comment_nx;
				if (!room)
					ovf_q <= 1'b1;
			end
			if (store_en) begin
				fill_q <= fill_q + cla_pkg::CNT_W'(1);
				if (!star_q) begin
					if (rx_byte == cla_pkg::CH_STAR)
						star_q <= 1'b1;
					else
						sum_q <= cla_pkg::sum_step(sum_q, rx_byte);
				end else if (!capt_q) begin
					chk_q  <= rx_byte;
					capt_q <= 1'b1;
				end
			end

			if (cmd.take_term) begin
				// settle the verdict, keep the last index, then clear the line state
				priority if (ovf_q)
					code_q <= cla_pkg::ST_OVF;
				else if (chk_fail)
					code_q <= cla_pkg::ST_CSUM;
				else
					code_q <= cla_pkg::ST_OK;
				last_idx_q <= fill_m1[cla_pkg::IDX_W-1:0];
				rd_q       <= '0;
				fill_q     <= '0;
				comment_q  <= 1'b0;
				ovf_q      <= 1'b0;
				sum_q      <= '0;
				star_q     <= 1'b0;
				chk_q      <= '0;
				capt_q     <= 1'b0;
			end

			if (cmd.put_data)
				rd_q <= rd_q + cla_pkg::IDX_W'(1);

			if (cmd.put_data || cmd.put_term)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_term)
			term_q <= rx_byte;
		if (cmd.put_data) begin
			out_byte_q <= rd_data_q;
			status_q   <= cla_pkg::ST_OK;
			last_q     <= 1'b0;
		end else if (cmd.put_term) begin
			out_byte_q <= term_q;
			status_q   <= code_q;
			last_q     <= 1'b1;
		end
	end

endmodule
`default_nettype wire

// ----- design/command_line_assembler_with_checksum_unit.sv -----
// Command line assembler with checksum.
// Input channel: rx_byte with in_valid / in_stall; a byte is taken at an edge where
// in_valid is high and in_stall is low. CR or LF ends a line; ';' opens a comment.
// Output channel: out_byte, status, last with out_valid / out_stall. A good line comes
// out as its stored bytes (status 0) and then the terminator with last set; an
// overflowed line (status 2) or a line whose checksum fails (status 1, only when
// check_enable is set) gives the terminator alone with last set.
// Configuration: check_enable with cfg_valid / cfg_ready; cfg_ready is always high.
// Sequencing: ordinary bytes are taken back to back while in_stall is low. A line
// end is first judged; then each stored byte goes through a registered read of the
// line store and then a load of the output register, and the terminator is loaded
// last. A failed, overflowed or empty line goes from the judgement straight to the
// terminator.
// While out_stall is high the output register holds its request and the stream
// pauses; once the terminator is loaded the block takes new bytes again even if that
// request still waits. Reset clears the controller, the line state and check_enable;
// the line store holds no reset value and is only read where written in this line.
`default_nettype none
module command_line_assembler_with_checksum_unit (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic       check_enable,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] rx_byte,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      out_byte,
	output logic [1:0]      status,
	output logic            last
);

	cla_pkg::cla_cmd_t cmd;
	cla_pkg::cla_sts_t sts;

	// the register write is always taken
	assign cfg_ready = 1'b1;

	// sequencing: judge the line, then step through the store
	cla_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// line store, checksum, flags and output register
	cla_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.check_enable (check_enable),
		.rx_byte      (rx_byte),
		.cmd          (cmd),
		.sts          (sts),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_byte     (out_byte),
		.status       (status),
		.last         (last)
	);

endmodule
`default_nettype wire

// ----- design/cla_checker.sv -----
`default_nettype none
module cla_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_stall,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic [7:0] out_byte,
	input wire logic [1:0] status,
	input wire logic       last
);

	// a stalled request holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(status)
			&& $stable(last))
		else $error("stalled request changed");

	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status != 2'd3)
		else $error("undefined status code");

	// an error verdict is always a one-request line
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != 2'd0 |-> last)
		else $error("error request without last");

	// results are only produced while input is held off
	a_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared while input was open");

endmodule

bind command_line_assembler_with_checksum_unit cla_checker u_cla_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_byte  (out_byte),
	.status    (status),
	.last      (last)
);
`default_nettype wire
